[rtl/core/rrs_pkg.sv]
// ----------------------------------------------------------------------------
// Random rotation sampler package
// Shared fixed-point constants, series divisors and status types.
// ----------------------------------------------------------------------------
package rrs_pkg;

    // Fixed-point landmarks
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [30:0] PI_Q29      = 31'd1686629713;
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [31:0] PI_HALF_Q30 = 32'd1686629713;
    localparam logic [32:0] PI_SCALED   = 33'h1_921F_B544;

    // Taylor series divisors, innermost Horner step first
    localparam int unsigned SERIES_STEPS = 6;
    localparam int unsigned SIN_KS [SERIES_STEPS] = '{156, 110, 72, 42, 20, 6};
    localparam int unsigned COS_KS [SERIES_STEPS] = '{182, 132, 90, 56, 30, 12};

    // Series unit latency: square stage, two stages per Horner step, final stage
    localparam int unsigned SERIES_LAT = 2 * SERIES_STEPS + 2;

    // Angle polynomial coefficients, Q.30 rounded
    localparam logic [63:0] C0_W = ((64'd2848346144 << 30) + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] C1_W = ((64'd2247894526 << 30) + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] C2_W = ((64'd4778870900 << 30) + 64'd50000000000)
                                   / 64'd100000000000;
    localparam logic [63:0] C3_W = ((64'd1350447708 << 30) + 64'd50000000000)
                                   / 64'd100000000000;
    localparam logic [63:0] C4_W = ((64'd5287525382 << 30) + 64'd500000000000)
                                   / 64'd1000000000000;
    localparam logic [63:0] C5_W = ((64'd1802678625 << 30) + 64'd500000000000)
                                   / 64'd1000000000000;
    localparam logic signed [32:0] COEF_C0 = $signed(C0_W[32:0]);
    localparam logic signed [32:0] COEF_C1 = $signed(C1_W[32:0]);
    localparam logic signed [32:0] COEF_C2 = $signed(C2_W[32:0]);
    localparam logic signed [32:0] COEF_C3 = $signed(C3_W[32:0]);
    localparam logic signed [32:0] COEF_C4 = $signed(C4_W[32:0]);
    localparam logic signed [32:0] COEF_C5 = $signed(C5_W[32:0]);

    // Scale unit status toward the datapath
    typedef struct packed {
        logic        busy;
        logic [30:0] k;
    } t_scale_status;

endpackage

[rtl/core/rrs_delay.sv]
// ----------------------------------------------------------------------------
// Delay line
// Shift register that carries a payload through DEPTH stages.
// ----------------------------------------------------------------------------
module rrs_delay #(
    parameter int unsigned W     = 8,
    parameter int unsigned DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_pipe [DEPTH];

    // Advance all taps together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_pipe[i] <= r_pipe[i-1];
            end
        end
    end

    assign o_q = r_pipe[DEPTH-1];

endmodule

[rtl/core/rrs_horner_cell.sv]
// ----------------------------------------------------------------------------
// Horner cell
// One series step acc' = 1 - floor(floor(x2*acc)/K), over two stages.
// ----------------------------------------------------------------------------
module rrs_horner_cell import rrs_pkg::*; #(
    parameter int unsigned K = 6
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_x2,
    input  logic [30:0] i_acc,
    output logic [31:0] o_x2,
    output logic [30:0] o_acc
);

    // Exact reciprocal for dividends below 2^32
    localparam int unsigned SHIFT_N = 32 + $clog2(K);
    localparam logic [63:0] RECIP_W = ((64'd1 << SHIFT_N) + 64'(K) - 64'd1) / 64'(K);
    localparam logic [32:0] RECIP   = RECIP_W[32:0];

    logic [63:0] n_prod;
    logic [64:0] n_quo_prod;
    logic [31:0] n_quo;
    logic [31:0] r_q;
    logic [31:0] r_x2_a;
    logic [31:0] r_x2_b;
    logic [30:0] r_acc;

    always_comb begin
        n_prod     = {32'd0, i_x2} * {33'd0, i_acc};
        n_quo_prod = {33'd0, r_q} * {32'd0, RECIP};
        n_quo      = 32'(n_quo_prod >> SHIFT_N);
    end

    // Stage one: product; stage two: divide and subtract from one
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q    <= n_prod[61:30];
            r_x2_a <= i_x2;
            r_acc  <= ONE_Q30 - n_quo[30:0];
            r_x2_b <= r_x2_a;
        end
    end

    assign o_x2  = r_x2_b;
    assign o_acc = r_acc;

endmodule

[rtl/core/rrs_series.sv]
// ----------------------------------------------------------------------------
// Sine / cosine series
// Taylor series on [0, pi/2] as a chain of Horner cells, fixed latency.
// ----------------------------------------------------------------------------
module rrs_series import rrs_pkg::*; #(
    parameter bit IS_COS = 1'b0
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_x,
    output logic [30:0] o_val
);

    logic [61:0] n_sq;
    logic [31:0] r_x2;
    logic [30:0] r_x0;
    logic [31:0] x2_c  [SERIES_STEPS+1];
    logic [30:0] acc_c [SERIES_STEPS+1];
    logic [30:0] r_val;

    assign n_sq = {31'd0, i_x} * {31'd0, i_x};

    // Square the argument
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x2 <= n_sq[61:30];
            r_x0 <= i_x;
        end
    end

    assign x2_c[0]  = r_x2;
    assign acc_c[0] = ONE_Q30;

    // Horner chain
    for (genvar g = 0; g < SERIES_STEPS; g++) begin : g_cell
        localparam int unsigned K = IS_COS ? COS_KS[g] : SIN_KS[g];
        rrs_horner_cell #(.K(K)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x2  (x2_c[g]),
            .i_acc (acc_c[g]),
            .o_x2  (x2_c[g+1]),
            .o_acc (acc_c[g+1])
        );
    end

    // Final multiply and clamp
    if (IS_COS) begin : g_cos
        logic [61:0] n_fin;
        logic [30:0] n_half;
        assign n_fin  = {30'd0, x2_c[SERIES_STEPS]} * {31'd0, acc_c[SERIES_STEPS]};
        assign n_half = n_fin[61:31];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_val <= (n_half > ONE_Q30) ? 31'd0 : (ONE_Q30 - n_half);
            end
        end
    end else begin : g_sin
        logic [30:0] x_d;
        logic [61:0] n_fin;
        rrs_delay #(.W(31), .DEPTH(2 * SERIES_STEPS)) u_xdly (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_d   (r_x0),
            .o_q   (x_d)
        );
        assign n_fin = {31'd0, x_d} * {31'd0, acc_c[SERIES_STEPS]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_val <= (n_fin[61:30] > {1'b0, ONE_Q30}) ? ONE_Q30 : n_fin[60:30];
            end
        end
    end

    assign o_val = r_val;

endmodule

[rtl/core/rrs_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// Square root cell
// One digit-by-digit integer square root step for a fixed bit weight.
// ----------------------------------------------------------------------------
module rrs_sqrt_cell #(
    parameter int unsigned POS = 0
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [60:0] i_w,
    input  logic [61:0] i_res,
    output logic [60:0] o_w,
    output logic [61:0] o_res
);

    localparam logic [61:0] BIT = 62'd1 << (2 * POS);

    logic [61:0] n_sum;
    logic [60:0] n_w;
    logic [61:0] n_res;
    logic [60:0] r_w;
    logic [61:0] r_res;

    // Trial subtract
    always_comb begin
        n_sum = i_res + BIT;
        if ({1'b0, i_w} >= n_sum) begin
            n_w   = i_w - n_sum[60:0];
            n_res = (i_res >> 1) + BIT;
        end else begin
            n_w   = i_w;
            n_res = i_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w   <= n_w;
            r_res <= n_res;
        end
    end

    assign o_w   = r_w;
    assign o_res = r_res;

endmodule

[rtl/core/rrs_cbrt_cell.sv]
// ----------------------------------------------------------------------------
// Cube root cell
// One digit-by-digit cube root step; keeps root and root squared.
// ----------------------------------------------------------------------------
module rrs_cbrt_cell #(
    parameter int unsigned G = 0
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [62:0] i_r,
    input  logic [28:0] i_t,
    input  logic [57:0] i_s,
    input  logic [29:0] i_y,
    output logic [62:0] o_r,
    output logic [28:0] o_t,
    output logic [57:0] o_s,
    output logic [29:0] o_y
);

    logic [2:0]  n_bits;
    logic [62:0] n_b;
    logic [62:0] n_rsh;
    logic [62:0] n_r;
    logic [28:0] n_t;
    logic [57:0] n_s;
    logic [62:0] r_r;
    logic [28:0] r_t;
    logic [57:0] r_s;
    logic [29:0] r_y;

    // Bring down the next group of three radicand bits
    if (G >= 19) begin : g_bits
        assign n_bits = i_y[3*(G-19) +: 3];
    end else begin : g_zero
        assign n_bits = 3'd0;
    end

    // Trial subtract of 12*t^2 + 6*t + 1
    always_comb begin
        n_b   = ({5'd0, i_s} << 3) + ({5'd0, i_s} << 2)
              + ({34'd0, i_t} << 2) + ({34'd0, i_t} << 1) + 63'd1;
        n_rsh = {i_r[59:0], n_bits};
        if (n_rsh >= n_b) begin
            n_r = n_rsh - n_b;
            n_t = {i_t[27:0], 1'b1};
            n_s = (i_s << 2) + ({29'd0, i_t} << 2) + 58'd1;
        end else begin
            n_r = n_rsh;
            n_t = {i_t[27:0], 1'b0};
            n_s = i_s << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r <= n_r;
            r_t <= n_t;
            r_s <= n_s;
            r_y <= i_y;
        end
    end

    assign o_r = r_r;
    assign o_t = r_t;
    assign o_s = r_s;
    assign o_y = r_y;

endmodule

[rtl/core/rrs_scale_unit.sv]
// ----------------------------------------------------------------------------
// Scale unit
// Holds the angle limit m and derives k = min((m - sin m) / pi, 1) after
// reset and after each write.
// ----------------------------------------------------------------------------
module rrs_scale_unit import rrs_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [30:0]   i_cfg_wdata,
    output t_scale_status o_status
);

    // Reciprocal of pi in Q.62 / Q.30 terms: floor(2^62 / PI_Q30)
    localparam logic [63:0] RCP_W  = (64'd1 << 62) / {32'd0, PI_Q30};
    localparam logic [31:0] RCP_PI = RCP_W[31:0];

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SIN  = 5'b00010,
        ST_RCP  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_FIX  = 5'b10000
    } t_state;

    t_state      r_state;
    logic [4:0]  r_cnt;
    logic [30:0] r_max;
    logic [31:0] r_d;
    logic [30:0] r_q;
    logic [63:0] r_prod;

    logic [30:0] n_m;
    logic [31:0] n_m30;
    logic [31:0] n_red;
    logic [30:0] sm;
    logic [31:0] n_d;
    logic [63:0] n_q0;
    logic [63:0] n_prod;
    logic [63:0] n_rem;

    // Fold the angle into the first quadrant and form the divide terms
    always_comb begin
        n_m    = (r_max > PI_Q29) ? PI_Q29 : r_max;
        n_m30  = {n_m, 1'b0};
        n_red  = (n_m30 > PI_HALF_Q30) ? (PI_Q30 - n_m30) : n_m30;
        n_d    = (n_m30 > {1'b0, sm}) ? (n_m30 - {1'b0, sm}) : 32'd0;
        n_q0   = {32'd0, r_d} * {32'd0, RCP_PI};
        n_prod = {33'd0, r_q} * {32'd0, PI_Q30};
        n_rem  = {2'b00, r_d, 30'd0} - r_prod;
    end

    rrs_series #(.IS_COS(1'b0)) u_sin (
        .i_clk (i_clk),
        .i_en  (1'b1),
        .i_x   (n_red[30:0]),
        .o_val (sm)
    );

    // Sequence: wait for the sine, estimate d / pi by reciprocal, correct once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SIN;
            r_cnt   <= 5'(SERIES_LAT + 1);
            r_max   <= PI_Q29;
        end else if (i_cfg_we) begin
            r_state <= ST_SIN;
            r_cnt   <= 5'(SERIES_LAT + 1);
            r_max   <= i_cfg_wdata;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_state <= ST_IDLE;
                end
                ST_SIN: begin
                    if (r_cnt == 5'd0) begin
                        r_d     <= n_d;
                        r_state <= ST_RCP;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                ST_RCP: begin
                    // Estimate is at most one below the true quotient
                    r_q     <= n_q0[62:32];
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_prod  <= n_prod;
                    r_state <= ST_FIX;
                end
                ST_FIX: begin
                    if (n_rem >= {32'd0, PI_Q30}) begin
                        r_q <= r_q + 31'd1;
                    end
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_status.busy = (r_state != ST_IDLE);
    assign o_status.k    = (r_q > ONE_Q30) ? ONE_Q30 : r_q;

endmodule

[rtl/core/random_rotation_sampler_unit.sv]
// ----------------------------------------------------------------------------
// Random rotation sampler
// Turns height, azimuth and angle samples into a unit axis and an angle.
// ----------------------------------------------------------------------------
// One transaction enters per clock while o_stall is low; the chain of cube
// root cells (29) and the angle polynomial stages behind it set the pipeline
// depth, with the square root cells (31) running alongside. After reset and
// after every angle limit write, o_stall stays high while the scale unit
// evaluates the sine of the limit and divides by pi with a reciprocal
// multiply and one correction step. Output stall freezes the pipe only when
// the last stage and the output register are both full.
// ----------------------------------------------------------------------------
module random_rotation_sampler_unit import rrs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic        [30:0] i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [30:0] i_height_sample,
    input  logic        [31:0] i_azimuth_fraction,
    input  logic signed [30:0] i_angle_sample,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_axis_x,
    output logic signed [31:0] o_axis_y,
    output logic signed [30:0] o_axis_z,
    output logic signed [31:0] o_rotation_angle
);

    localparam int unsigned PIPE_LAT = 37;

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } t_quad;

    // Signed Q.30 product, truncated toward zero
    function automatic logic signed [32:0] mulq(input logic signed [32:0] a,
                                               input logic signed [32:0] b);
        logic        neg;
        logic [32:0] ma;
        logic [32:0] mb;
        logic [65:0] p;
        logic [32:0] m;
        neg = a[32] ^ b[32];
        ma  = a[32] ? 33'(-a) : 33'(a);
        mb  = b[32] ? 33'(-b) : 33'(b);
        p   = {33'd0, ma} * {33'd0, mb};
        m   = p[62:30];
        return neg ? $signed(-m) : $signed(m);
    endfunction

    t_scale_status scale;
    logic          en;
    logic          accept;
    logic          out_load;
    logic [PIPE_LAT-1:0] r_vld;

    rrs_scale_unit u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_status    (scale)
    );

    // Handshake
    assign en       = !(r_vld[PIPE_LAT-1] && o_valid && i_stall);
    assign o_stall  = scale.busy || !en;
    assign accept   = i_valid && !o_stall;
    assign out_load = r_vld[PIPE_LAT-1] && (!o_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[PIPE_LAT-2:0], accept};
            end
            if (out_load) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    // ---- Stage 1: magnitudes, radicand, angle argument, scaled sample ----
    logic [30:0] n_au;
    logic [30:0] n_ap;
    logic [61:0] n_au2;
    logic [62:0] n_th;
    logic [61:0] n_aym;
    logic [60:0] r1_w;
    logic [30:0] r1_th;
    logic [1:0]  r1_quad;
    logic [30:0] r1_aym;
    logic        r1_neg;
    logic [30:0] r1_u;

    always_comb begin
        n_au  = i_height_sample[30] ? 31'(-i_height_sample) : 31'(i_height_sample);
        n_ap  = i_angle_sample[30] ? 31'(-i_angle_sample) : 31'(i_angle_sample);
        n_au2 = {31'd0, n_au} * {31'd0, n_au};
        n_th  = {33'd0, i_azimuth_fraction[29:0]} * {30'd0, PI_SCALED};
        n_aym = {31'd0, n_ap} * {31'd0, scale.k};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_w    <= (61'd1 << 60) - n_au2[60:0];
            r1_th   <= n_th[62:32];
            r1_quad <= i_azimuth_fraction[31:30];
            r1_aym  <= n_aym[60:30];
            r1_neg  <= i_angle_sample[30];
            r1_u    <= i_height_sample;
        end
    end

    // ---- Square root chain: stages 2..32 ----
    logic [60:0] w_c   [32];
    logic [61:0] res_c [32];
    assign w_c[0]   = r1_w;
    assign res_c[0] = '0;

    for (genvar g = 0; g < 31; g++) begin : g_sqrt
        rrs_sqrt_cell #(.POS(30 - g)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_w   (w_c[g]),
            .i_res (res_c[g]),
            .o_w   (w_c[g+1]),
            .o_res (res_c[g+1])
        );
    end

    // ---- Sine and cosine: stages 2..15 ----
    logic [30:0] cos_v;
    logic [30:0] sin_v;
    logic [1:0]  quad15;

    rrs_series #(.IS_COS(1'b1)) u_cos (
        .i_clk (i_clk), .i_en (en), .i_x (r1_th), .o_val (cos_v)
    );
    rrs_series #(.IS_COS(1'b0)) u_sin (
        .i_clk (i_clk), .i_en (en), .i_x (r1_th), .o_val (sin_v)
    );
    rrs_delay #(.W(2), .DEPTH(SERIES_LAT)) u_quad_dly (
        .i_clk (i_clk), .i_en (en), .i_d (r1_quad), .o_q (quad15)
    );

    // Place cosine and sine by quadrant
    logic signed [31:0] n_cx;
    logic signed [31:0] n_cy;
    logic signed [31:0] c_pos;
    logic signed [31:0] s_pos;

    always_comb begin
        c_pos = $signed({1'b0, cos_v});
        s_pos = $signed({1'b0, sin_v});
        case (t_quad'(quad15))
            QUAD_I:   begin n_cx = c_pos;  n_cy = s_pos;  end
            QUAD_II:  begin n_cx = -s_pos; n_cy = c_pos;  end
            QUAD_III: begin n_cx = -c_pos; n_cy = -s_pos; end
            QUAD_IV:  begin n_cx = s_pos;  n_cy = -c_pos; end
            default:  begin n_cx = c_pos;  n_cy = s_pos;  end
        endcase
    end

    logic [63:0] cxy32;
    rrs_delay #(.W(64), .DEPTH(32 - SERIES_LAT - 1)) u_cxy_dly (
        .i_clk (i_clk), .i_en (en), .i_d ({n_cx, n_cy}), .o_q (cxy32)
    );

    // ---- Stage 33: scale the circle by sqrt(1-u^2) ----
    logic signed [32:0] v33;
    logic signed [31:0] r33_ax;
    logic signed [31:0] r33_ay;
    assign v33 = $signed({2'b00, res_c[31][30:0]});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r33_ax <= 32'(mulq(v33, 33'($signed(cxy32[63:32]))));
            r33_ay <= 32'(mulq(v33, 33'($signed(cxy32[31:0]))));
        end
    end

    logic [63:0] axy37;
    rrs_delay #(.W(64), .DEPTH(4)) u_axy_dly (
        .i_clk (i_clk), .i_en (en), .i_d ({r33_ax, r33_ay}), .o_q (axy37)
    );

    // ---- Cube root chain: stages 2..30 ----
    logic [62:0] cr_c [30];
    logic [28:0] ct_c [30];
    logic [57:0] cs_c [30];
    logic [29:0] cy_c [30];
    assign cr_c[0] = '0;
    assign ct_c[0] = '0;
    assign cs_c[0] = '0;
    assign cy_c[0] = r1_aym[29:0];

    for (genvar g = 0; g < 29; g++) begin : g_cbrt
        rrs_cbrt_cell #(.G(28 - g)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_r   (cr_c[g]),
            .i_t   (ct_c[g]),
            .i_s   (cs_c[g]),
            .i_y   (cy_c[g]),
            .o_r   (cr_c[g+1]),
            .o_t   (ct_c[g+1]),
            .o_s   (cs_c[g+1]),
            .o_y   (cy_c[g+1])
        );
    end

    logic sat30;
    logic neg36;
    rrs_delay #(.W(1), .DEPTH(29)) u_sat_dly (
        .i_clk (i_clk), .i_en (en), .i_d (r1_aym[30]), .o_q (sat30)
    );
    rrs_delay #(.W(1), .DEPTH(35)) u_neg_dly (
        .i_clk (i_clk), .i_en (en), .i_d (r1_neg), .o_q (neg36)
    );

    // ---- Stage 31: t and z = 2t^2 - 1 ----
    logic [29:0] n_t30;
    logic [59:0] n_tt;
    logic [29:0] r_t [31:36];
    logic signed [32:0] r_z [31:35];
    logic signed [32:0] r_h [32:36];

    always_comb begin
        n_t30 = sat30 ? (30'd1 << 29) : {1'b0, ct_c[29]};
        n_tt  = {30'd0, n_t30} * {30'd0, n_t30};
    end

    // ---- Stages 32..36: Horner polynomial in z ----
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t[31] <= n_t30;
            r_z[31] <= $signed({1'b0, n_tt[58:27]}) - $signed({2'b00, ONE_Q30});
            for (int s = 32; s <= 36; s++) begin
                r_t[s] <= r_t[s-1];
            end
            for (int s = 32; s <= 35; s++) begin
                r_z[s] <= r_z[s-1];
            end
            r_h[32] <= mulq(r_z[31], COEF_C5);
            r_h[33] <= mulq(r_z[32], COEF_C4 + r_h[32]);
            r_h[34] <= mulq(r_z[33], COEF_C3 + r_h[33]);
            r_h[35] <= mulq(r_z[34], COEF_C2 + r_h[34]);
            r_h[36] <= mulq(r_z[35], COEF_C1 + r_h[35]);
        end
    end

    // ---- Stage 37: angle = t * R(z), saturated, signed ----
    logic signed [32:0] n_rr;
    logic [62:0]        n_mag_p;
    logic [31:0]        n_mag;
    logic [31:0]        n_mag_sat;
    logic signed [31:0] r37_ang;
    logic [30:0]        u37;

    always_comb begin
        n_rr      = COEF_C0 + r_h[36];
        n_mag_p   = {33'd0, r_t[36]} * {31'd0, n_rr[31:0]};
        n_mag     = (n_rr > 33'sd0) ? n_mag_p[61:30] : 32'd0;
        n_mag_sat = (n_mag > {1'b0, PI_Q29}) ? {1'b0, PI_Q29} : n_mag;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r37_ang <= neg36 ? $signed(-n_mag_sat) : $signed(n_mag_sat);
        end
    end

    rrs_delay #(.W(31), .DEPTH(PIPE_LAT - 1)) u_u_dly (
        .i_clk (i_clk), .i_en (en), .i_d (r1_u), .o_q (u37)
    );

    // ---- Output register ----
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_axis_x         <= $signed(axy37[63:32]);
            o_axis_y         <= $signed(axy37[31:0]);
            o_axis_z         <= $signed(u37);
            o_rotation_angle <= r37_ang;
        end
    end

endmodule

[rtl/core/rrs_checker.sv]
// ----------------------------------------------------------------------------
// Random rotation sampler checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rrs_checker import rrs_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_axis_x,
    input logic signed [31:0] o_axis_y,
    input logic signed [30:0] o_axis_z,
    input logic signed [31:0] o_rotation_angle
);

    // Hold a stalled transaction
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result transaction dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_axis_x) && $stable(o_axis_y)
                               && $stable(o_axis_z) && $stable(o_rotation_angle))
        else $error("stalled result payload changed");

    // X and y axis components stay on the unit interval
    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_axis_x <= 32'sh4000_0000) && (o_axis_x >= -32'sh4000_0000)
                 && (o_axis_y <= 32'sh4000_0000) && (o_axis_y >= -32'sh4000_0000))
        else $error("axis component beyond unit range");

    // Angle saturates at plus or minus pi
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rotation_angle <= $signed({1'b0, PI_Q29}))
                 && (o_rotation_angle >= -$signed({1'b0, PI_Q29})))
        else $error("rotation angle beyond pi");

endmodule

bind random_rotation_sampler_unit rrs_checker u_rrs_checker (.*);

[tb/sv/tb_random_rotation_sampler_unit.sv]
// ----------------------------------------------------------------------------
// Random rotation sampler testbench
// Drives sample transactions through the rotation sampler under several
// angle limit settings, predicts the axis and angle in fixed point and
// compares every result in order.
// ----------------------------------------------------------------------------
module tb_random_rotation_sampler_unit import rrs_pkg::*;;

    // Expected rotation for one accepted sample transaction
    typedef struct {
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [30:0] axis_z;
        logic signed [31:0] angle;
    } rotation_t;

    // Fixed-point rotation predictor with its own copy of the angle limit
    class rotation_scoreboard;
        logic [30:0] angle_limit;
        rotation_t   pending[$];
        int          errors;

        function new();
            angle_limit = PI_Q29;
            errors      = 0;
        endfunction

        function automatic longint mul_q30(longint a, longint b);
            bit      neg;
            longint  ua;
            longint  ub;
            longint unsigned prod;
            neg  = (a < 0) != (b < 0);
            ua   = a < 0 ? -a : a;
            ub   = b < 0 ? -b : b;
            prod = (longint'(ua) * longint'(ub)) >> 30;
            return neg ? -longint'(prod) : longint'(prod);
        endfunction

        function automatic longint unsigned int_sqrt(longint unsigned w);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > w) bitv >>= 2;
            while (bitv != 0) begin
                if (w >= res + bitv) begin
                    w   = w - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        function automatic longint series_sin(longint unsigned x);
            longint unsigned x2;
            longint unsigned acc;
            x2  = (x * x) >> 30;
            acc = 64'd1 << 30;
            for (int i = 0; i < SERIES_STEPS; i++)
                acc = (64'd1 << 30) - ((x2 * acc) >> 30) / SIN_KS[i];
            acc = (x * acc) >> 30;
            return acc > (64'd1 << 30) ? (64'd1 << 30) : acc;
        endfunction

        function automatic longint series_cos(longint unsigned x);
            longint unsigned x2;
            longint unsigned acc;
            longint          c;
            x2  = (x * x) >> 30;
            acc = 64'd1 << 30;
            for (int i = 0; i < SERIES_STEPS; i++)
                acc = (64'd1 << 30) - ((x2 * acc) >> 30) / COS_KS[i];
            c = (64'd1 << 30) - longint'(((x2 * acc) >> 30) / 2);
            return c < 0 ? 0 : c;
        endfunction

        function automatic longint unsigned cube_root(longint unsigned y);
            longint unsigned r;
            longint unsigned t;
            longint unsigned grp;
            longint unsigned y2;
            longint unsigned b;
            r = 0;
            t = 0;
            for (int g = 28; g >= 0; g--) begin
                grp = g >= 19 ? (y >> (3 * (g - 19))) & 7 : 0;
                y2  = t << 1;
                b   = 3 * y2 * (y2 + 1) + 1;
                r   = (r << 3) | grp;
                if (r >= b) begin
                    r = r - b;
                    t = y2 + 1;
                end else begin
                    t = y2;
                end
            end
            return t;
        endfunction

        // Note an accepted sample and queue its predicted rotation
        function void note_sample(logic signed [30:0] hgt, logic [31:0] az,
                                  logic signed [30:0] smp);
            rotation_t       res;
            longint          u;
            longint          p;
            longint          c;
            longint          s;
            longint          cx;
            longint          cy;
            longint          sm;
            longint          z;
            longint          r;
            longint          ang;
            longint unsigned au;
            longint unsigned v;
            longint unsigned th;
            longint unsigned m;
            longint unsigned m30;
            longint unsigned red;
            longint unsigned d;
            longint unsigned k;
            longint unsigned ap;
            longint unsigned ym;
            longint unsigned t;
            longint unsigned mag;
            u  = hgt;
            p  = smp;
            au = u < 0 ? -u : u;
            v  = int_sqrt((64'd1 << 60) - au * au);
            th = ((longint'(az) & 64'h3FFF_FFFF) * longint'(PI_SCALED)) >> 32;
            c  = series_cos(th);
            s  = series_sin(th);
            case (az[31:30])
                2'd0: begin cx = c;  cy = s;  end
                2'd1: begin cx = -s; cy = c;  end
                2'd2: begin cx = -c; cy = -s; end
                default: begin cx = s; cy = -c; end
            endcase
            res.axis_x = 32'(mul_q30(v, cx));
            res.axis_y = 32'(mul_q30(v, cy));
            res.axis_z = hgt;

            // Inverse CDF for the angle
            m   = angle_limit > PI_Q29 ? PI_Q29 : angle_limit;
            m30 = m << 1;
            red = m30 > PI_HALF_Q30 ? PI_Q30 - m30 : m30;
            sm  = series_sin(red);
            d   = longint'(m30) > sm ? m30 - sm : 0;
            k   = (d << 30) / PI_Q30;
            if (k > (64'd1 << 30)) k = 64'd1 << 30;
            ap  = p < 0 ? -p : p;
            ym  = (ap * k) >> 30;
            t   = ym >= (64'd1 << 30) ? (64'd1 << 29) : cube_root(ym);
            z   = longint'((t * t) >> 27) - (longint'(1) << 30);
            r   = mul_q30(z, COEF_C5);
            r   = mul_q30(z, COEF_C4 + r);
            r   = mul_q30(z, COEF_C3 + r);
            r   = mul_q30(z, COEF_C2 + r);
            r   = mul_q30(z, COEF_C1 + r);
            r   = COEF_C0 + r;
            mag = r > 0 ? (t * longint'(r)) >> 30 : 0;
            if (mag > PI_Q29) mag = PI_Q29;
            ang = p < 0 ? -longint'(mag) : longint'(mag);
            res.angle = 32'(ang);
            pending.push_back(res);
        endfunction

        // Check one result against the oldest prediction
        function void check_rotation(rotation_t got);
            rotation_t exp_r;
            if (pending.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.axis_x !== exp_r.axis_x) begin
                $error("axis_x expected %0d actual %0d", exp_r.axis_x, got.axis_x);
                errors++;
            end
            if (got.axis_y !== exp_r.axis_y) begin
                $error("axis_y expected %0d actual %0d", exp_r.axis_y, got.axis_y);
                errors++;
            end
            if (got.axis_z !== exp_r.axis_z) begin
                $error("axis_z expected %0d actual %0d", exp_r.axis_z, got.axis_z);
                errors++;
            end
            if (got.angle !== exp_r.angle) begin
                $error("rotation_angle expected %0d actual %0d", exp_r.angle, got.angle);
                errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int RANDOM_ITEMS   = 1600;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic        [30:0] cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [30:0] height = '0;
    logic        [31:0] azimuth = '0;
    logic signed [30:0] sample = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [30:0] axis_z;
    logic signed [31:0] angle;

    rotation_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  hold_off = 1'b0;

    always #5 clk = ~clk;

    random_rotation_sampler_unit dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_wdata        (cfg_wdata),
        .i_valid            (in_valid),
        .o_stall            (in_stall),
        .i_height_sample    (height),
        .i_azimuth_fraction (azimuth),
        .i_angle_sample     (sample),
        .o_valid            (out_valid),
        .i_stall            (out_stall),
        .o_axis_x           (axis_x),
        .o_axis_y           (axis_y),
        .o_axis_z           (axis_z),
        .o_rotation_angle   (angle)
    );

    // Note accepted inputs, check accepted outputs, count idle cycles
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) sb.note_sample(height, azimuth, sample);
            if (out_valid && !out_stall) sb.check_rotation('{axis_x, axis_y, axis_z, angle});
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Stall the output on a pattern of its own, with one long hold-off
    initial begin
        int mode;
        forever begin
            @(negedge clk);
            if (hold_off) begin
                out_stall <= 1'b1;
                repeat (200) @(negedge clk);
                hold_off = 1'b0;
            end
            mode = $urandom_range(0, 9);
            if (mode < 3) out_stall <= 1'b0;
            else if (mode < 5) out_stall <= ($urandom_range(0, 3) == 0);
            else out_stall <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 30)) begin
                @(negedge clk);
                if (mode >= 3 && mode < 5) out_stall <= ($urandom_range(0, 3) == 0);
                else if (mode >= 5) out_stall <= 1'($urandom_range(0, 1));
            end
        end
    end

    // Offer one sample transaction and hold it until accepted
    task automatic send_sample(logic signed [30:0] h, logic [31:0] a,
                               logic signed [30:0] s);
        in_valid <= 1'b1;
        height   <= h;
        azimuth  <= a;
        sample   <= s;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic idle_input(int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Wait for all predictions to be consumed, then settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_angle_limit(logic [30:0] val);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        sb.angle_limit = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [30:0] rand_q30();
        return 31'($urandom);
    endfunction

    // Random burst phase with random gaps
    task automatic random_phase(int n);
        int sent;
        int burst;
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && sent < n; i++) begin
                send_sample(rand_q30(), $urandom, rand_q30());
                sent++;
            end
            if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 8));
        end
    endtask

    initial begin
        logic [30:0] angles[5];
        logic signed [30:0] edge_h[4];
        logic signed [30:0] edge_p[4];
        angles   = '{31'd0, 31'd1, 31'd843314856, 31'h7FFF_FFFF, PI_Q29};
        edge_h   = '{-31'sd1073741824, 31'sd1073741823, 31'sd0, -31'sd1};
        edge_p   = '{-31'sd1073741824, 31'sd1073741823, 31'sd0, 31'sd1};
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: field extremes, quadrant boundaries, minus-one sample at pi
        for (int i = 0; i < 4; i++) begin
            send_sample(edge_h[i], 32'h0000_0000, edge_p[i]);
            send_sample(edge_h[3 - i], 32'hFFFF_FFFF, edge_p[3 - i]);
            send_sample(edge_h[i], 32'h4000_0000 * i, edge_p[i]);
            send_sample(edge_h[i], 32'h3FFF_FFFF + 32'h4000_0000 * i, edge_p[3 - i]);
        end
        send_sample(31'sd0, 32'h5555_5555, -31'sd1073741824);
        send_sample(31'sd0, 32'hAAAA_AAAA, 31'sd536870912);
        drain();

        // Long output hold-off while input keeps flowing
        hold_off = 1'b1;
        random_phase(100);
        drain();

        // Sweep angle limit settings including extremes and above pi
        for (int j = 0; j < 5; j++) begin
            write_angle_limit(angles[j]);
            send_sample(-31'sd1073741824, $urandom, -31'sd1073741824);
            send_sample(31'sd1073741823, $urandom, 31'sd1073741823);
            random_phase((RANDOM_ITEMS - 100) / 5);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
